### src/ramsc_pkg.sv
package ramsc_pkg;

    // item kinds carried in tuser
    localparam logic [1:0] OP_CIGAR = 2'd0;
    localparam logic [1:0] OP_MD    = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // cigar operation codes
    localparam logic [3:0] CIG_M  = 4'd0;
    localparam logic [3:0] CIG_I  = 4'd1;
    localparam logic [3:0] CIG_D  = 4'd2;
    localparam logic [3:0] CIG_EQ = 4'd7;
    localparam logic [3:0] CIG_X  = 4'd8;

    // scoring modes
    localparam logic [1:0] MODE_MATCH = 2'd0;
    localparam logic [1:0] MODE_AS    = 2'd1;
    localparam logic [1:0] MODE_MAPQ  = 2'd2;
    localparam logic [1:0] MODE_RANK  = 2'd3;

    // md string characters
    localparam logic [7:0] MD_NUL      = 8'h00;
    localparam logic [7:0] MD_DEL_MARK = 8'h5E;
    localparam logic [7:0] MD_DIGIT_LO = 8'h30;
    localparam logic [7:0] MD_DIGIT_HI = 8'h39;

    // rank values for the rank mode: mapped b outranks a, unmapped b ranks lowest
    localparam logic [31:0] RANK_FROM_A      = 32'd1;
    localparam logic [31:0] RANK_B_MAPPED    = 32'd2;
    localparam logic [31:0] RANK_B_UNMAPPED  = 32'd0;

    // accumulator and score limits
    localparam logic [47:0] MT_MAX    = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] MT_MIN    = 48'h8000_0000_0000;
    localparam logic [47:0] IND_MAX   = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] MDM_MAX   = 32'hFFFF_FFFF;
    localparam logic [31:0] SCORE_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         cigar_code;
        logic [27:0]        cigar_length;
        logic [7:0]         md_character;
        logic               nm_present;
        logic signed [31:0] nm_count;
        logic               md_present;
        logic               as_present;
        logic signed [31:0] as_score;
        logic [7:0]         map_quality;
        logic               unmapped;
        logic               from_input_a;
    } item_t;

    typedef struct packed {
        logic [31:0] score;
        logic        missing_as_tag;
        logic        nm_anomaly;
        logic        no_mismatch_info;
    } result_t;

endpackage

### src/ramsc_score.sv
module ramsc_score import ramsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  item_t       item,
    input  logic [1:0]  mode,
    output result_t     res
);

    logic [47:0] match_total_reg, match_total_next;
    logic [47:0] indel_total_reg, indel_total_next;
    logic        saw_exact_reg, saw_exact_next;
    logic        md_in_del_reg, md_in_del_next;
    logic [31:0] md_mm_reg, md_mm_next;

    logic signed [48:0] mt_delta;
    logic signed [48:0] mt_sum;
    logic [48:0]        ind_sum;
    logic [47:0]        mt_sat;
    logic [47:0]        ind_sat;
    logic               is_digit;

    logic signed [49:0] nm_diff;
    logic [32:0]        mm_sub;
    logic signed [49:0] s_val;
    logic               resolved;
    logic               anomaly;

    // saturating adders on the running totals
    always_comb begin
        mt_delta = 49'sd0;
        case (item.cigar_code)
            CIG_M, CIG_EQ: mt_delta = $signed({21'd0, item.cigar_length});
            CIG_D:         mt_delta = -$signed({21'd0, item.cigar_length});
            default:       mt_delta = 49'sd0;
        endcase
        mt_sum = $signed({match_total_reg[47], match_total_reg}) + mt_delta;
        if (mt_sum[48] != mt_sum[47]) begin
            mt_sat = mt_sum[48] ? MT_MIN : MT_MAX;
        end else begin
            mt_sat = mt_sum[47:0];
        end
        ind_sum = {1'b0, indel_total_reg} + {21'd0, item.cigar_length};
        ind_sat = ind_sum[48] ? IND_MAX : ind_sum[47:0];
        is_digit = (item.md_character >= MD_DIGIT_LO) && (item.md_character <= MD_DIGIT_HI);
    end

    // next state per beat kind
    always_comb begin
        match_total_next = match_total_reg;
        indel_total_next = indel_total_reg;
        saw_exact_next   = saw_exact_reg;
        md_in_del_next   = md_in_del_reg;
        md_mm_next       = md_mm_reg;
        case (item.op)
            OP_CIGAR: begin
                case (item.cigar_code)
                    CIG_EQ: begin
                        saw_exact_next   = 1'b1;
                        match_total_next = mt_sat;
                    end
                    CIG_M: match_total_next = mt_sat;
                    CIG_D: begin
                        indel_total_next = ind_sat;
                        match_total_next = mt_sat;
                    end
                    CIG_X: saw_exact_next = 1'b1;
                    CIG_I: indel_total_next = ind_sat;
                    default: ;
                endcase
            end
            OP_MD: begin
                if (item.md_character == MD_DEL_MARK) begin
                    md_in_del_next = 1'b1;
                end else if (is_digit) begin
                    md_in_del_next = 1'b0;
                end else if (item.md_character != MD_NUL && !md_in_del_reg) begin
                    if (md_mm_reg != MDM_MAX) begin
                        md_mm_next = md_mm_reg + 32'd1;
                    end
                end
            end
            OP_END: begin
                match_total_next = '0;
                indel_total_next = '0;
                saw_exact_next   = 1'b0;
                md_in_del_next   = 1'b0;
                md_mm_next       = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_total_reg <= '0;
            indel_total_reg <= '0;
            saw_exact_reg   <= 1'b0;
            md_in_del_reg   <= 1'b0;
            md_mm_reg       <= '0;
        end else if (step) begin
            match_total_reg <= match_total_next;
            indel_total_reg <= indel_total_next;
            saw_exact_reg   <= saw_exact_next;
            md_in_del_reg   <= md_in_del_next;
            md_mm_reg       <= md_mm_next;
        end
    end

    // mismatch source: exact ops, then nm minus indels, then md letters
    always_comb begin
        nm_diff  = $signed({{18{item.nm_count[31]}}, item.nm_count})
                 - $signed({2'b00, indel_total_reg});
        resolved = saw_exact_reg;
        anomaly  = 1'b0;
        mm_sub   = '0;
        if (!resolved && item.nm_present) begin
            if (nm_diff[49]) begin
                anomaly = 1'b1;
            end else begin
                mm_sub   = nm_diff[32:0];
                resolved = 1'b1;
            end
        end
        if (!resolved && item.md_present) begin
            resolved = 1'b1;
            mm_sub   = {1'b0, md_mm_reg};
        end
        s_val = $signed({{2{match_total_reg[47]}}, match_total_reg})
              - $signed({17'd0, mm_sub});
    end

    // result for a record end
    always_comb begin
        res = '0;
        case (mode)
            MODE_MATCH: begin
                res.nm_anomaly       = anomaly;
                res.no_mismatch_info = !resolved;
                if (s_val[49]) begin
                    res.score = '0;
                end else if (s_val > $signed({18'd0, SCORE_MAX})) begin
                    res.score = SCORE_MAX;
                end else begin
                    res.score = s_val[31:0];
                end
            end
            MODE_AS: begin
                if (item.as_present) begin
                    res.score = item.as_score;
                end else begin
                    res.missing_as_tag = 1'b1;
                end
            end
            MODE_MAPQ: res.score = {24'd0, item.map_quality};
            default: begin
                if (item.from_input_a) begin
                    res.score = RANK_FROM_A;
                end else if (!item.unmapped) begin
                    res.score = RANK_B_MAPPED;
                end else begin
                    res.score = RANK_B_UNMAPPED;
                end
            end
        endcase
    end

endmodule

### src/read_alignment_match_score_core.sv
// Alignment record scorer. Each record streams in as cigar beats, then md
// character beats, then one record-end beat (tuser = 2) carrying the tag and
// flag values; only the record-end beat yields a result beat. One beat is
// taken per clock with no gaps between records, unless a record end stalls
// on a full result register. A record-end result passes the input register
// and then the result register, with the running totals updated in between.
// The user must write the scoring mode through cfg_we/cfg_wdata while the
// block is idle, which is not enforced; it is sampled at each record end.
module read_alignment_match_score_core import ramsc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cigar_code, cigar_length, md_character, nm_present, nm_count,
    // md_present, as_present, as_score, map_quality, unmapped, from_input_a
    input  logic [119:0] s_axis_tdata,
    // op
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // score
    output logic [31:0]  m_axis_tdata,
    // missing_as_tag, nm_anomaly, no_mismatch_info
    output logic [2:0]   m_axis_tuser
);

    logic [1:0] mode_reg;
    logic       in_valid_reg;
    item_t      item_reg;
    item_t      item_in;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    res;
    logic       advance;
    logic       is_end;

    // unpack the input beat
    always_comb begin
        item_in.op           = s_axis_tuser;
        item_in.cigar_code   = s_axis_tdata[3:0];
        item_in.cigar_length = s_axis_tdata[31:4];
        item_in.md_character = s_axis_tdata[39:32];
        item_in.nm_present   = s_axis_tdata[40];
        item_in.nm_count     = s_axis_tdata[72:41];
        item_in.md_present   = s_axis_tdata[73];
        item_in.as_present   = s_axis_tdata[74];
        item_in.as_score     = s_axis_tdata[106:75];
        item_in.map_quality  = s_axis_tdata[114:107];
        item_in.unmapped     = s_axis_tdata[115];
        item_in.from_input_a = s_axis_tdata[116];
    end

    // flow control: only record ends need room in the result register
    assign is_end        = (item_reg.op == OP_END);
    assign advance       = in_valid_reg && (!is_end || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_MATCH;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            item_reg <= item_in;
        end
    end

    ramsc_score u_score (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item_reg),
        .mode    (mode_reg),
        .res     (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && is_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && is_end) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.score;
    assign m_axis_tuser  = {out_reg.no_mismatch_info, out_reg.nm_anomaly, out_reg.missing_as_tag};

endmodule

### test/tb.sv
module tb;
    import ramsc_pkg::*;

    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int          LIMIT_CYCLES = 400000;
    localparam int          HOLD_LEN     = 300;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [27:0] LEN_MAX      = 28'hFFF_FFFF;
    localparam longint      MATCH_HI     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint      MATCH_LO     = -MATCH_HI - 1;
    localparam longint      INDEL_HI     = 64'sh0000_FFFF_FFFF_FFFF;
    localparam longint      MDMISS_HI    = 64'sh0000_0000_FFFF_FFFF;
    localparam longint      SCORE_HI     = 64'sd2147483647;

    // receiver stall patterns
    localparam int RX_ALWAYS   = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_SPARSE   = 3;

    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         cfg_we        = 1'b0;
    logic [1:0]   cfg_wdata     = 2'd0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = 2'd0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    read_alignment_match_score_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // scorer state mirrored by the testbench
    logic [1:0] mode_q      = MODE_MATCH;
    longint     acc_match   = 0;
    longint     acc_indel   = 0;
    bit         acc_exact   = 1'b0;
    bit         acc_in_del  = 1'b0;
    longint     acc_md_miss = 0;

    result_t expected_scores[$];
    result_t want_q;
    int      errors      = 0;
    int      items_sent  = 0;
    int      cycle_count = 0;
    int      burst_left  = 0;
    bit      no_gaps     = 1'b0;
    int      rx_style    = RX_ALWAYS;
    int      rx_tick     = 0;
    int      hold_asks   = 0;
    int      hold_done   = 0;
    int      hold_left   = 0;

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic longint clamp_match(longint v);
        if (v > MATCH_HI) return MATCH_HI;
        if (v < MATCH_LO) return MATCH_LO;
        return v;
    endfunction

    function automatic longint clamp_indel(longint v);
        return (v > INDEL_HI) ? INDEL_HI : v;
    endfunction

    // expected scorer behavior for one beat
    task automatic score_model_step(input item_t it, output bit has_res, output result_t res);
        longint len;
        longint s;
        longint nm;
        bit     resolved;
        has_res = 1'b0;
        res     = '0;
        len     = {36'd0, it.cigar_length};
        case (it.op)
            OP_CIGAR: begin
                case (it.cigar_code)
                    CIG_M: acc_match = clamp_match(acc_match + len);
                    CIG_EQ: begin
                        acc_exact = 1'b1;
                        acc_match = clamp_match(acc_match + len);
                    end
                    CIG_D: begin
                        acc_indel = clamp_indel(acc_indel + len);
                        acc_match = clamp_match(acc_match - len);
                    end
                    CIG_I: acc_indel = clamp_indel(acc_indel + len);
                    CIG_X: acc_exact = 1'b1;
                    default: ;
                endcase
            end
            OP_MD: begin
                if (it.md_character == MD_DEL_MARK)
                    acc_in_del = 1'b1;
                else if (it.md_character >= MD_DIGIT_LO && it.md_character <= MD_DIGIT_HI)
                    acc_in_del = 1'b0;
                else if (it.md_character != MD_NUL && !acc_in_del && acc_md_miss < MDMISS_HI)
                    acc_md_miss++;
            end
            OP_END: begin
                has_res = 1'b1;
                case (mode_q)
                    MODE_MATCH: begin
                        s        = acc_match;
                        resolved = acc_exact;
                        if (!resolved && it.nm_present) begin
                            nm = longint'(it.nm_count);
                            if (nm < acc_indel) begin
                                res.nm_anomaly = 1'b1;
                            end else begin
                                s        = s - (nm - acc_indel);
                                resolved = 1'b1;
                            end
                        end
                        if (!resolved && it.md_present) begin
                            resolved = 1'b1;
                            s        = s - acc_md_miss;
                        end
                        res.no_mismatch_info = !resolved;
                        if (s < 0) s = 0;
                        if (s > SCORE_HI) s = SCORE_HI;
                        res.score = s[31:0];
                    end
                    MODE_AS: begin
                        if (it.as_present) res.score = it.as_score;
                        else res.missing_as_tag = 1'b1;
                    end
                    MODE_MAPQ: res.score = {24'd0, it.map_quality};
                    default: begin
                        if (it.from_input_a) res.score = RANK_FROM_A;
                        else if (!it.unmapped) res.score = RANK_B_MAPPED;
                        else res.score = RANK_B_UNMAPPED;
                    end
                endcase
                acc_match   = 0;
                acc_indel   = 0;
                acc_exact   = 1'b0;
                acc_in_del  = 1'b0;
                acc_md_miss = 0;
            end
            default: ;
        endcase
    endtask

    // drive one beat and wait for it to be taken
    task automatic send_item(input item_t it);
        bit      has_res;
        result_t res;
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {3'b000, it.from_input_a, it.unmapped, it.map_quality, it.as_score,
                          it.as_present, it.md_present, it.nm_count, it.nm_present,
                          it.md_character, it.cigar_length, it.cigar_code};
        do @(posedge aclk); while (!s_axis_tready);
        score_model_step(it, has_res, res);
        if (has_res) expected_scores.insert(expected_scores.size(), res);
        if (it.op != OP_UNUSED) items_sent++;
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    // bursts of beats with random gaps in between, unless gaps are turned off
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            if (!no_gaps) idle_cycles($urandom_range(1, 10));
        end
    endtask

    // drop valid, let every result drain, then allow the pipeline to settle
    task automatic wait_idle();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        wait_idle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        mode_q     = m;
    endtask

    function automatic item_t cigar_beat(input logic [3:0] code, input logic [27:0] len);
        item_t it;
        it              = '0;
        it.op           = OP_CIGAR;
        it.cigar_code   = code;
        it.cigar_length = len;
        return it;
    endfunction

    function automatic item_t md_beat(input logic [7:0] ch);
        item_t it;
        it              = '0;
        it.op           = OP_MD;
        it.md_character = ch;
        return it;
    endfunction

    function automatic item_t end_beat(input bit nm_p, input logic [31:0] nm, input bit md_p,
                                       input bit as_p, input logic [31:0] as_v,
                                       input logic [7:0] mapq, input bit unm, input bit from_a);
        item_t it;
        it              = '0;
        it.op           = OP_END;
        it.nm_present   = nm_p;
        it.nm_count     = nm;
        it.md_present   = md_p;
        it.as_present   = as_p;
        it.as_score     = as_v;
        it.map_quality  = mapq;
        it.unmapped     = unm;
        it.from_input_a = from_a;
        return it;
    endfunction

    function automatic item_t random_item();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(item_t)-1:0];
    endfunction

    task automatic send_cigar_run(input int n, input bit big);
        item_t it;
        int    r;
        repeat (n) begin
            it    = random_item();
            it.op = OP_CIGAR;
            if (big) begin
                it.cigar_code   = ($urandom_range(0, 1) == 0) ? CIG_M : CIG_EQ;
                it.cigar_length = LEN_MAX - 28'($urandom_range(0, 15));
            end else begin
                r = $urandom_range(0, 15);
                if (r < 4) it.cigar_code = CIG_M;
                else if (r < 6) it.cigar_code = CIG_I;
                else if (r < 8) it.cigar_code = CIG_D;
                else if (r < 10) it.cigar_code = CIG_EQ;
                else if (r < 12) it.cigar_code = CIG_X;
                r = $urandom_range(0, 9);
                if (r < 7) it.cigar_length = 28'($urandom_range(0, 300));
                else if (r == 8) it.cigar_length = LEN_MAX;
                else if (r == 9) it.cigar_length = '0;
            end
            send_item(it);
            pace();
        end
    endtask

    task automatic send_md_run(input int n);
        item_t it;
        int    r;
        string bases;
        bases = "ACGT";
        repeat (n) begin
            it    = random_item();
            it.op = OP_MD;
            r     = $urandom_range(0, 9);
            if (r < 3) it.md_character = MD_DIGIT_LO + 8'($urandom_range(0, 9));
            else if (r == 3) it.md_character = MD_DEL_MARK;
            else if (r < 8) it.md_character = bases[$urandom_range(0, 3)];
            else if (r == 8) it.md_character = MD_NUL;
            send_item(it);
            pace();
        end
    endtask

    // one record: cigar beats, md beats (now and then before the cigar beats), record end, with occasional noise
    task automatic send_random_record();
        item_t  it;
        int     n_md;
        int     r;
        bit     big;
        bit     md_first;
        longint nm_val;
        big      = ($urandom_range(0, 24) == 0);
        n_md     = $urandom_range(0, 8);
        md_first = ($urandom_range(0, 9) == 0);
        if (md_first) send_md_run(n_md);
        send_cigar_run(big ? $urandom_range(8, 12) : $urandom_range(0, 6), big);
        if ($urandom_range(0, 14) == 0) begin
            it    = random_item();
            it.op = OP_UNUSED;
            send_item(it);
            pace();
        end
        if (!md_first) send_md_run(n_md);
        it            = random_item();
        it.op         = OP_END;
        it.nm_present = ($urandom_range(0, 9) < 7);
        r             = $urandom_range(0, 3);
        // nm near the indel count, just under it, small, or fully random
        if (r == 0 && acc_indel < 64'sd2000000000) begin
            nm_val      = acc_indel + $urandom_range(0, 20);
            it.nm_count = nm_val[31:0];
        end else if (r == 1) begin
            nm_val      = acc_indel - 1;
            it.nm_count = nm_val[31:0];
        end else if (r == 2) begin
            it.nm_count = 32'($urandom_range(0, 20));
        end
        send_item(it);
        pace();
    endtask

    task automatic test_match_directed();
        write_mode(MODE_MATCH);
        // =/X seen: nm and md are not consulted
        send_item(cigar_beat(CIG_M, LEN_MAX));
        send_item(cigar_beat(CIG_I, 28'd5));
        send_item(cigar_beat(CIG_D, 28'd3));
        send_item(cigar_beat(CIG_EQ, 28'd7));
        send_item(cigar_beat(CIG_X, 28'd2));
        send_item(cigar_beat(4'hF, 28'd100));
        send_item(end_beat(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 8'hFF, 1'b1, 1'b1));
        // md letters inside a deletion, nul character and unused op ignored
        send_item(cigar_beat(CIG_M, 28'd20));
        send_item(md_beat(MD_DEL_MARK));
        send_item(md_beat("C"));
        send_item(md_beat(MD_DIGIT_LO + 8'd2));
        send_item(md_beat("T"));
        send_item(md_beat(MD_NUL));
        send_item('{op: OP_UNUSED, default: '1});
        send_item(end_beat(1'b0, 32'd0, 1'b1, 1'b0, 32'd0, 8'd0, 1'b0, 1'b0));
        // nm below the indel count, no md
        send_item(cigar_beat(CIG_I, 28'd4));
        send_item(cigar_beat(CIG_M, 28'd10));
        send_item(end_beat(1'b1, 32'd2, 1'b0, 1'b0, 32'd0, 8'd0, 1'b0, 1'b0));
        // negative running total clamps at zero
        send_item(cigar_beat(CIG_D, 28'd100));
        send_item(end_beat(1'b1, 32'd103, 1'b0, 1'b0, 32'd0, 8'd0, 1'b0, 1'b0));
        wait_idle();
    endtask

    task automatic test_as_mode();
        write_mode(MODE_AS);
        send_item(end_beat(1'b1, 32'd0, 1'b1, 1'b1, 32'h7FFF_FFFF, 8'd0, 1'b0, 1'b0));
        send_item(end_beat(1'b1, 32'd0, 1'b1, 1'b1, 32'h8000_0000, 8'd0, 1'b0, 1'b0));
        send_item(end_beat(1'b0, 32'd0, 1'b0, 1'b0, 32'h1234_5678, 8'd0, 1'b0, 1'b0));
        wait_idle();
    endtask

    task automatic test_mapq_mode();
        write_mode(MODE_MAPQ);
        send_item(end_beat(1'b0, 32'd0, 1'b0, 1'b0, 32'd0, 8'hFF, 1'b0, 1'b0));
        send_item(end_beat(1'b0, 32'd0, 1'b0, 1'b0, 32'd0, 8'h00, 1'b1, 1'b1));
        wait_idle();
    endtask

    task automatic test_rank_mode();
        write_mode(MODE_RANK);
        send_item(end_beat(1'b0, 32'd0, 1'b0, 1'b0, 32'd0, 8'd0, 1'b1, 1'b1));
        send_item(end_beat(1'b0, 32'd0, 1'b0, 1'b0, 32'd0, 8'd0, 1'b0, 1'b0));
        send_item(end_beat(1'b0, 32'd0, 1'b0, 1'b0, 32'd0, 8'd0, 1'b1, 1'b0));
        wait_idle();
    endtask

    task automatic run_random_phase(input logic [1:0] m, input int n, input int style,
                                    input bit gapless);
        int target;
        write_mode(m);
        rx_style = style;
        no_gaps  = gapless;
        target   = items_sent + n;
        while (items_sent < target) send_random_record();
    endtask

    task automatic test_random_stream();
        run_random_phase(MODE_MATCH, 300, RX_COIN, 1'b0);
        run_random_phase(MODE_RANK, 150, RX_PERIODIC, 1'b0);
        run_random_phase(MODE_MATCH, 300, RX_ALWAYS, 1'b1);
        run_random_phase(MODE_AS, 150, RX_SPARSE, 1'b0);
        run_random_phase(MODE_MAPQ, 150, RX_COIN, 1'b0);
        run_random_phase(MODE_MATCH, 400, RX_PERIODIC, 1'b0);
        run_random_phase(2'($urandom_range(0, 3)), 200, RX_COIN, 1'b0);
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        write_mode(MODE_MATCH);
        rx_style = RX_ALWAYS;
        no_gaps  = 1'b1;
        hold_asks++;
        repeat (30) send_random_record();
        wait_idle();
        no_gaps = 1'b0;
    endtask

    // receiver ready pattern, with long hold-offs on request
    always @(negedge aclk) begin
        if (hold_done != hold_asks) begin
            hold_done = hold_asks;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_style)
                RX_ALWAYS:   m_axis_tready <= 1'b1;
                RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: m_axis_tready <= ((rx_tick % 7) < 4);
                default:     m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
        rx_tick++;
    end

    // check each result beat against the oldest expected score
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_scores.size() == 0) begin
                $display("%0t: result beat with nothing expected: score %h flags %b",
                         $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want_q = expected_scores.pop_front();
                if (m_axis_tdata !== want_q.score) begin
                    $display("%0t: score expected %h actual %h", $time, want_q.score,
                             m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser[0] !== want_q.missing_as_tag) begin
                    $display("%0t: missing_as_tag expected %b actual %b", $time,
                             want_q.missing_as_tag, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tuser[1] !== want_q.nm_anomaly) begin
                    $display("%0t: nm_anomaly expected %b actual %b", $time,
                             want_q.nm_anomaly, m_axis_tuser[1]);
                    errors++;
                end
                if (m_axis_tuser[2] !== want_q.no_mismatch_info) begin
                    $display("%0t: no_mismatch_info expected %b actual %b", $time,
                             want_q.no_mismatch_info, m_axis_tuser[2]);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        test_match_directed();
        test_as_mode();
        test_mapq_mode();
        test_rank_mode();
        test_backpressure();
        test_random_stream();
        wait_idle();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
src/ramsc_pkg.sv
src/ramsc_score.sv
src/read_alignment_match_score_core.sv
test/tb.sv
